>>> rtl/kclcd_pkg.sv
// ----------------------------------------------------------------------------
// kclcd_pkg: shared types and constants of the key click detector
// Key phases, event kinds, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package kclcd_pkg;

	// per-key phase of the scan state machine
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_PRESSED  = 3'd2,
		PH_GAP      = 3'd3,
		PH_LONG     = 3'd4
	} phase_t;

	// reported event kinds
	typedef enum logic [1:0] {
		EV_CLICK = 2'd0,
		EV_LONG  = 2'd1,
		EV_COMBO = 2'd2
	} event_kind_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_MASK = 3'd0,
		REG_DEBOUNCE   = 3'd1,
		REG_LONG_PRESS = 3'd2,
		REG_CLICK_GAP  = 3'd3,
		REG_COMBO      = 3'd4
	} reg_idx_t;

	localparam int unsigned DEFAULT_NUM_KEYS = 3;

	localparam int unsigned DEB_W   = 4;
	localparam int unsigned HOLD_W  = 8;
	localparam int unsigned GAP_W   = 4;
	localparam int unsigned CLICK_W = 3;

	localparam logic [CLICK_W-1:0] CLICK_MAX = 3'd7;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 4'd1;
	localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 8'd80;
	localparam logic [GAP_W-1:0]  CLICK_GAP_RESET  = 4'd5;
	localparam int unsigned       COMBO_RESET      = 78;

endpackage

>>> rtl/key_click_long_combo_detector.sv
// ----------------------------------------------------------------------------
// key_click_long_combo_detector: multi-key click, long press and combo detector
// Scans one key per tick through debounce, press, click gap and long press.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, raw_levels) carries one tick request with
//   the raw level of every key. Each request not swallowed by the release
//   wait visits one key, chosen by a rotating scan index, and advances that key's phase machine.
//   out channel (out_valid/out_ready) carries at most one event per request:
//   a click burst with its count, a long press, or a combination with the
//   first held partner key.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes a register;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   a request is registered at acceptance; its event lands in the output
//   register as the request leaves, and one request per cycle is taken unless
//   the input register waits. It only waits when its request raises an event
//   while the output register is full and out_ready is low; requests without an
//   event keep flowing past a stalled output.
// Reset:
//   arst_n clears every key to idle, the scan index to key 0, the release
//   wait flag, and loads the register reset values.
// ----------------------------------------------------------------------------
module key_click_long_combo_detector #(
	parameter int unsigned NUM_KEYS = kclcd_pkg::DEFAULT_NUM_KEYS,
	localparam int unsigned KW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
	localparam int unsigned CW   = NUM_KEYS * NUM_KEYS,
	localparam int unsigned CFGW = (CW > kclcd_pkg::HOLD_W) ? CW : kclcd_pkg::HOLD_W
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [NUM_KEYS-1:0]            raw_levels,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     event_kind,
	output logic [KW-1:0]                  event_key,
	output logic [kclcd_pkg::CLICK_W-1:0]  click_total,
	output logic [KW-1:0]                  partner_key,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kclcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFGW-1:0]                cfg_data
);
	import kclcd_pkg::*;

	// configuration registers
	logic [NUM_KEYS-1:0] level_mask_q;
	logic [DEB_W-1:0]    debounce_ticks_q;
	logic [HOLD_W-1:0]   long_ticks_q;
	logic [GAP_W-1:0]    gap_ticks_q;
	logic [CW-1:0]       combo_q;

	// per-key state
	phase_t             phase_q [NUM_KEYS];
	logic [DEB_W-1:0]   deb_q   [NUM_KEYS];
	logic [HOLD_W-1:0]  hold_q  [NUM_KEYS];
	logic [GAP_W-1:0]   gap_q   [NUM_KEYS];
	logic [CLICK_W-1:0] click_q [NUM_KEYS];
	logic [KW-1:0]      scan_q;
	logic               release_wait_q;

	// input register
	logic                valid_s1;
	logic [NUM_KEYS-1:0] raw_s1;

	// output register
	logic               out_valid_q;
	event_kind_t        ev_kind_q;
	logic [KW-1:0]      ev_key_q;
	logic [CLICK_W-1:0] ev_clicks_q;
	logic [KW-1:0]      ev_partner_q;

	// next-state logic
	logic [NUM_KEYS-1:0] held;
	logic                do_scan;
	logic                emit;
	logic                advance;
	logic                is_down;
	phase_t              nx_phase;
	logic [DEB_W-1:0]    nx_deb;
	logic [HOLD_W-1:0]   nx_hold;
	logic [GAP_W-1:0]    nx_gap;
	logic [CLICK_W-1:0]  nx_click;
	logic                nx_release;
	event_kind_t         nx_kind;
	logic [KW-1:0]       nx_partner;
	logic [NUM_KEYS-1:0] partners;
	logic                found;
	logic [KW-1:0]       scan_next;

	assign held      = ~(raw_s1 ^ level_mask_q);
	assign is_down   = held[scan_q];
	assign partners  = combo_q[scan_q*NUM_KEYS +: NUM_KEYS];
	assign scan_next = (scan_q == KW'(NUM_KEYS - 1)) ? '0 : scan_q + 1'b1;
	// while waiting for release, a tick with any key held is swallowed
	assign do_scan   = !(release_wait_q && (held != '0));

	// first held partner, lowest index wins
	always_comb begin
		found      = 1'b0;
		nx_partner = '0;
		for (int j = NUM_KEYS - 1; j >= 0; j--) begin
			if (partners[j] && held[j]) begin
				found      = 1'b1;
				nx_partner = KW'(j);
			end
		end
	end

	always_comb begin
		nx_phase   = phase_q[scan_q];
		nx_deb     = deb_q[scan_q];
		nx_hold    = hold_q[scan_q];
		nx_gap     = gap_q[scan_q];
		nx_click   = click_q[scan_q];
		nx_release = 1'b0;
		nx_kind    = EV_CLICK;
		emit       = 1'b0;
		case (phase_q[scan_q])
			PH_IDLE: begin
				if (is_down) begin
					nx_phase = PH_DEBOUNCE;
					nx_deb   = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (deb_q[scan_q] < debounce_ticks_q) begin
					nx_deb = deb_q[scan_q] + 1'b1;
				end else if (is_down) begin
					nx_phase = PH_PRESSED;
					nx_hold  = '0;
				end else begin
					nx_phase = PH_IDLE;
					nx_deb   = '0;
					nx_hold  = '0;
					nx_gap   = '0;
					nx_click = '0;
				end
			end
			PH_PRESSED: begin
				if (!is_down) begin
					if (click_q[scan_q] != CLICK_MAX) begin
						nx_click = click_q[scan_q] + 1'b1;
					end
					nx_phase = PH_GAP;
					nx_gap   = '0;
				end else if (hold_q[scan_q] < long_ticks_q) begin
					nx_hold = hold_q[scan_q] + 1'b1;
				end else begin
					nx_phase = PH_LONG;
				end
			end
			PH_GAP: begin
				if (gap_q[scan_q] < gap_ticks_q) begin
					nx_gap = gap_q[scan_q] + 1'b1;
					if (is_down) begin
						nx_phase = PH_DEBOUNCE;
						nx_deb   = '0;
					end
				end else begin
					emit     = 1'b1;
					nx_kind  = EV_CLICK;
					nx_phase = PH_IDLE;
					nx_deb   = '0;
					nx_hold  = '0;
					nx_gap   = '0;
					nx_click = '0;
				end
			end
			PH_LONG: begin
				emit       = 1'b1;
				nx_kind    = found ? EV_COMBO : EV_LONG;
				nx_release = 1'b1;
				nx_phase   = PH_IDLE;
				nx_deb     = '0;
				nx_hold    = '0;
				nx_gap     = '0;
				nx_click   = '0;
			end
			default: begin
				nx_phase = PH_IDLE;
				nx_deb   = '0;
				nx_hold  = '0;
				nx_gap   = '0;
				nx_click = '0;
			end
		endcase
		if (!do_scan) begin
			emit = 1'b0;
		end
	end

	// the input stage only waits when its event cannot enter the output register
	assign advance  = valid_s1 && !(emit && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				phase_q[k] <= PH_IDLE;
				deb_q[k]   <= '0;
				hold_q[k]  <= '0;
				gap_q[k]   <= '0;
				click_q[k] <= '0;
			end
			scan_q         <= '0;
			release_wait_q <= 1'b0;
		end else if (advance && do_scan) begin
			phase_q[scan_q] <= nx_phase;
			deb_q[scan_q]   <= nx_deb;
			hold_q[scan_q]  <= nx_hold;
			gap_q[scan_q]   <= nx_gap;
			click_q[scan_q] <= nx_click;
			scan_q          <= scan_next;
			release_wait_q  <= nx_release;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ev_kind_q    <= nx_kind;
			ev_key_q     <= scan_q;
			ev_clicks_q  <= (nx_kind == EV_CLICK) ? click_q[scan_q] : '0;
			ev_partner_q <= (nx_kind == EV_COMBO) ? nx_partner : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = ev_kind_q;
	assign event_key   = ev_key_q;
	assign click_total = ev_clicks_q;
	assign partner_key = ev_partner_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mask_q     <= '0;
			debounce_ticks_q <= DEBOUNCE_RESET;
			long_ticks_q     <= LONG_PRESS_RESET;
			gap_ticks_q      <= CLICK_GAP_RESET;
			combo_q          <= CW'(COMBO_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEVEL_MASK: level_mask_q     <= cfg_data[NUM_KEYS-1:0];
				REG_DEBOUNCE:   debounce_ticks_q <= cfg_data[DEB_W-1:0];
				REG_LONG_PRESS: long_ticks_q     <= cfg_data[HOLD_W-1:0];
				REG_CLICK_GAP:  gap_ticks_q      <= cfg_data[GAP_W-1:0];
				REG_COMBO:      combo_q          <= cfg_data[CW-1:0];
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a waiting input request means its event is blocked by a full output
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |-> (out_valid_q && !out_ready))
		else $error("input stage stalled without a blocked output");

	// a long press or combination arms the release wait
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && (nx_kind != EV_CLICK)) |=> release_wait_q)
		else $error("release wait not set after long press");

	// swallowed ticks while keys are held do not move the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && release_wait_q && (held != '0)) |=> $stable(scan_q))
		else $error("scan moved while waiting for release");

	// a click burst always carries at least one click, other kinds none
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((ev_kind_q == EV_CLICK) == (ev_clicks_q != '0)))
		else $error("click count does not match event kind");

	assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= KW'(NUM_KEYS - 1))
		else $error("scan index beyond last key");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for key_click_long_combo_detector
// Drives tick requests with held-key patterns and noise under several register
// settings, predicts every click burst, long press and combination in a
// scoreboard model, and checks each reported event in order.
// ----------------------------------------------------------------------------
module testbench;
	import kclcd_pkg::*;

	localparam int KEYS        = DEFAULT_NUM_KEYS;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		event_kind_t kind;
		logic [1:0]  key;
		logic [2:0]  clicks;
		logic [1:0]  partner;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic            in_valid = 1'b0;
	logic            in_ready;
	logic [KEYS-1:0] raw_levels = '0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] event_kind;
	logic [1:0] event_key;
	logic [2:0] click_total;
	logic [1:0] partner_key;

	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [2:0]     cfg_index = REG_LEVEL_MASK;
	logic [8:0]     cfg_data = '0;

	// scoreboard copy of the key scanner
	phase_t      key_ph [KEYS];
	logic [3:0]  settle_cnt [KEYS];
	logic [7:0]  hold_cnt [KEYS];
	logic [3:0]  gap_cnt [KEYS];
	logic [2:0]  burst_cnt [KEYS];
	int          scan_key;
	bit          wait_release;

	logic [2:0]  cfg_level;
	logic [3:0]  cfg_settle;
	logic [7:0]  cfg_hold;
	logic [3:0]  cfg_gap;
	logic [8:0]  cfg_partners;

	key_event_t pending_events[$];

	int  errors;
	int  ticks_sent;
	int  clicks_seen;
	int  longs_seen;
	int  combos_seen;
	int  reg_writes;
	bit  idle_on = 1'b1;
	int  stall_req;
	int  stall_left;
	int  quiet_cycles;

	key_click_long_combo_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.raw_levels  (raw_levels),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.event_key   (event_key),
		.click_total (click_total),
		.partner_key (partner_key),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	task automatic clear_key_state(input int k);
		key_ph[k] = PH_IDLE;
		settle_cnt[k] = '0;
		hold_cnt[k] = '0;
		gap_cnt[k] = '0;
		burst_cnt[k] = '0;
	endtask

	task automatic reset_scanner();
		for (int k = 0; k < KEYS; k++) clear_key_state(k);
		scan_key = 0;
		wait_release = 1'b0;
		cfg_level = '0;
		cfg_settle = DEBOUNCE_RESET;
		cfg_hold = LONG_PRESS_RESET;
		cfg_gap = CLICK_GAP_RESET;
		cfg_partners = 9'(COMBO_RESET);
	endtask

	task automatic push_event(input event_kind_t kind, input int k, input logic [2:0] clicks,
			input int partner);
		key_event_t ev;
		ev.kind = kind;
		ev.key = 2'(k);
		ev.clicks = clicks;
		ev.partner = 2'(partner);
		pending_events.push_back(ev);
	endtask

	// one scan step per accepted tick request
	task automatic predict_scan(input logic [KEYS-1:0] raw);
		logic [KEYS-1:0] held;
		logic [KEYS-1:0] partners;
		bit found;
		int k;
		held = ~(raw ^ cfg_level);
		if (wait_release) begin
			if (held != '0) return;
			wait_release = 1'b0;
		end
		k = scan_key;
		case (key_ph[k])
			PH_IDLE: begin
				if (held[k]) begin
					key_ph[k] = PH_DEBOUNCE;
					settle_cnt[k] = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (settle_cnt[k] < cfg_settle) begin
					settle_cnt[k]++;
				end else if (held[k]) begin
					key_ph[k] = PH_PRESSED;
					hold_cnt[k] = '0;
				end else begin
					clear_key_state(k);
				end
			end
			PH_PRESSED: begin
				if (!held[k]) begin
					if (burst_cnt[k] < CLICK_MAX) burst_cnt[k]++;
					key_ph[k] = PH_GAP;
					gap_cnt[k] = '0;
				end else if (hold_cnt[k] < cfg_hold) begin
					hold_cnt[k]++;
				end else begin
					key_ph[k] = PH_LONG;
				end
			end
			PH_GAP: begin
				if (gap_cnt[k] < cfg_gap) begin
					gap_cnt[k]++;
					if (held[k]) begin
						key_ph[k] = PH_DEBOUNCE;
						settle_cnt[k] = '0;
					end
				end else begin
					push_event(EV_CLICK, k, burst_cnt[k], 0);
					clear_key_state(k);
				end
			end
			PH_LONG: begin
				partners = cfg_partners[k*KEYS +: KEYS];
				found = 1'b0;
				// lowest held partner wins
				for (int j = 0; j < KEYS; j++) begin
					if (!found && partners[j] && held[j]) begin
						push_event(EV_COMBO, k, '0, j);
						found = 1'b1;
					end
				end
				if (!found) push_event(EV_LONG, k, '0, 0);
				clear_key_state(k);
				wait_release = 1'b1;
			end
			default: clear_key_state(k);
		endcase
		scan_key = (k + 1 >= KEYS) ? 0 : k + 1;
	endtask

	function automatic logic [KEYS-1:0] level_of(input logic [KEYS-1:0] held);
		return (~held) ^ cfg_level;
	endfunction

	task automatic apply_register(input reg_idx_t idx, input logic [8:0] value);
		case (idx)
			REG_LEVEL_MASK: cfg_level = value[KEYS-1:0];
			REG_DEBOUNCE:   cfg_settle = value[3:0];
			REG_LONG_PRESS: cfg_hold = value[7:0];
			REG_CLICK_GAP:  cfg_gap = value[3:0];
			REG_COMBO:      cfg_partners = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	// writes all five registers, with junk in the bits above each width but the combination's
	task automatic write_config(input logic [2:0] lvl, input logic [3:0] deb,
			input logic [7:0] lng, input logic [3:0] gap, input logic [8:0] combo);
		reg_idx_t order [5];
		logic [8:0] value;
		order = '{REG_LEVEL_MASK, REG_DEBOUNCE, REG_LONG_PRESS, REG_CLICK_GAP, REG_COMBO};
		foreach (order[i]) begin
			case (order[i])
				REG_LEVEL_MASK: value = {6'($urandom), lvl};
				REG_DEBOUNCE:   value = {5'($urandom), deb};
				REG_LONG_PRESS: value = {1'($urandom), lng};
				REG_CLICK_GAP:  value = {5'($urandom), gap};
				default:        value = combo;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= value;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_register(order[i], value);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(input logic [KEYS-1:0] raw);
		while (idle_on && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_levels <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_scan(raw);
		ticks_sent++;
	endtask

	// sender pauses until every predicted event has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// held-key patterns with release gaps, plus some raw noise
	task automatic run_presses(input int count, input int seg_max);
		int start;
		int len;
		int pick;
		int k;
		logic [KEYS-1:0] held;
		start = ticks_sent;
		while (ticks_sent - start < count) begin
			pick = $urandom_range(99);
			k = $urandom_range(KEYS - 1);
			if (pick < 15) begin
				len = $urandom_range(1, 6);
				repeat (len) send_tick(KEYS'($urandom));
			end else begin
				if (pick < 55) held = KEYS'(1) << k;
				else if (pick < 75) held = ~(KEYS'(1) << k);
				else if (pick < 88) held = '1;
				else held = KEYS'($urandom);
				len = $urandom_range(1, seg_max);
				repeat (len) send_tick(level_of(held));
				len = $urandom_range(1, seg_max);
				repeat (len) send_tick(level_of('0));
			end
		end
	endtask

	task automatic run_phase(input logic [2:0] lvl, input logic [3:0] deb,
			input logic [7:0] lng, input logic [3:0] gap, input logic [8:0] combo,
			input int count, input int seg_max);
		write_config(lvl, deb, lng, gap, combo);
		run_presses(count, seg_max);
		wait_drained();
	endtask

	task automatic test_default_settings();
		run_presses(50, 30);
		wait_drained();
	endtask

	// all keys held into a combination on key 0, long presses of keys 1 and 2, a key 0 press swallowed
	task automatic test_directed();
		write_config(3'b111, 4'd0, 8'd1, 4'd1, 9'h016);
		repeat (13) send_tick(3'b111);
		send_tick(3'b111);
		repeat (2) send_tick(3'b000);
		repeat (6) send_tick(3'b001);
		repeat (9) send_tick(3'b000);
		wait_drained();
	endtask

	task automatic test_setting_sweep();
		run_phase(3'($urandom), 4'd0, 8'd1, 4'd1, 9'h000, 60, 12);
		run_phase(3'($urandom), 4'd2, 8'd4, 4'd3, 9'($urandom), 60, 24);
		// zero hold and gap limits: compare fails on the first visit
		run_phase(3'($urandom), 4'd1, 8'd0, 4'd0, 9'h1FF, 40, 10);
		idle_on = 1'b0;
		run_phase(3'($urandom), 4'd15, 8'd20, 4'd15, 9'($urandom), 60, 140);
		idle_on = 1'b1;
		run_phase(3'($urandom), 4'($urandom_range(3)), 8'($urandom_range(1, 12)),
			4'($urandom_range(1, 6)), 9'($urandom), 60, 20);
	endtask

	// longest hold limit; key 0 lists itself as a partner
	task automatic test_longest_hold();
		write_config(3'b000, 4'd0, 8'd255, 4'd15, 9'h1FF);
		repeat (786) send_tick(level_of(3'b101));
		repeat (12) send_tick(level_of('0));
		wait_drained();
	endtask

	// receiver holds off while requests keep coming
	task automatic test_output_stall();
		write_config(3'($urandom), 4'd0, 8'd1, 4'd1, 9'($urandom));
		idle_on = 1'b0;
		stall_req = 300;
		run_presses(100, 8);
		idle_on = 1'b1;
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (stall_req > 0) begin
			stall_left = stall_req;
			stall_req = 0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(99) < 11);
		end
	end

	always @(posedge clk) begin
		key_event_t ev;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected event: kind %0d key %0d clicks %0d partner %0d",
						event_kind, event_key, click_total, partner_key);
			end else begin
				ev = pending_events.pop_front();
				if (event_kind != ev.kind || event_key != ev.key ||
						click_total != ev.clicks || partner_key != ev.partner) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: expected kind %0d key %0d clicks %0d partner %0d, %s",
							ev.kind, ev.key, ev.clicks, ev.partner,
							$sformatf("got kind %0d key %0d clicks %0d partner %0d",
								event_kind, event_key, click_total, partner_key));
				end
				case (ev.kind)
					EV_CLICK: clicks_seen++;
					EV_LONG:  longs_seen++;
					default:  combos_seen++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		reset_scanner();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_default_settings();
		test_directed();
		test_setting_sweep();
		test_longest_hold();
		test_output_stall();
		wait_drained();
		$display("%0d tick requests, %0d register writes across 9 settings", ticks_sent,
			reg_writes);
		$display("events checked: %0d click bursts, %0d long presses, %0d combinations",
			clicks_seen, longs_seen, combos_seen);
		if (errors == 0 && pending_events.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
rtl/kclcd_pkg.sv
rtl/key_click_long_combo_detector.sv
bench/testbench.sv
